FILE: sv/assert_macros.svh
// assertion macros shared by the mask run box extractor modules
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: sv/mrbe_pkg.sv
// shared types, field widths and codes for the mask run box extractor
// no dependencies
package mrbe_pkg;

    // default sizing
    localparam int MAX_BOXES_DEF  = 256;
    localparam int COORD_BITS_DEF = 12;
    localparam int FIFO_DEPTH     = 4;

    // port field widths
    localparam int IMG_W_W  = 13;
    localparam int CLASS_W  = 2;
    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 8;
    localparam int LEFT_W   = 12;
    localparam int TOP_W    = 12;
    localparam int BWIDTH_W = 13;
    localparam int HEIGHT_W = 13;

    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST = 13'd640;
    localparam logic [INDEX_W-1:0] DROP_INDEX      = 8'd255;

    // pixel classes
    localparam logic [CLASS_W-1:0] PIX_BLACK = 2'd0;
    localparam logic [CLASS_W-1:0] PIX_WHITE = 2'd1;

    // result event codes
    typedef enum logic [KIND_W-1:0] {
        EV_NEW  = 2'd0,
        EV_GROW = 2'd1,
        EV_DROP = 2'd2
    } mrbe_event_t;

    // back end sequencer
    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_COL,
        BK_CHK,
        BK_SRD,
        BK_SCK,
        BK_EMIT
    } mrbe_state_t;

    // control part of one queued job
    typedef struct packed {
        logic clear;    // frame start: empty the box table
        logic close;    // a run closed on this pixel
        logic wrapped;  // row counter wrapped in this frame
    } mrbe_job_ctl_t;

endpackage

FILE: sv/mrbe_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module mrbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/mrbe_fifo.sv
// small job queue between the pixel front end and the box back end
// uses assert_macros.svh
`include "assert_macros.svh"

module mrbe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW:0] DEPTH_CNT = (AW + 1)'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      fill_reg, fill_next;

    assign full     = (fill_reg == DEPTH_CNT);
    assign empty    = (fill_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + (AW + 1)'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - (AW + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ASSERT_NEVER(a_fifo_overflow, push && full, "job pushed into a full queue")
    `ASSERT_NEVER(a_fifo_underflow, pop && empty, "job popped from an empty queue")
    `ASSERT_NEVER(a_fifo_fill_range, fill_reg > DEPTH_CNT, "queue fill count out of range")

endmodule

FILE: sv/mrbe_front.sv
// pixel front end: image width register, column/row/run tracking, job issue
// depends on mrbe_pkg
module mrbe_front #(
    parameter int COORD_BITS = mrbe_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [mrbe_pkg::IMG_W_W-1:0] cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [mrbe_pkg::CLASS_W-1:0] pixel_class,
    input  logic                         frame_start,
    input  logic                         init_done,
    input  logic                         push_full,
    output logic                         push_valid,
    output mrbe_pkg::mrbe_job_ctl_t      push_ctl,
    output logic [COORD_BITS-1:0]        push_start,
    output logic [COORD_BITS:0]          push_width,
    output logic [COORD_BITS-1:0]        push_row
);

    import mrbe_pkg::*;

    localparam int CW     = COORD_BITS;
    localparam int SPAN_I = 1 << CW;
    localparam int CMP_W  = (IMG_W_W > CW + 1) ? IMG_W_W : CW + 1;
    localparam logic [CW:0]      SPAN   = SPAN_I[CW:0];
    localparam logic [CMP_W-1:0] SPAN_X = SPAN_I[CMP_W-1:0];

    logic [IMG_W_W-1:0] img_w_reg;
    logic [CW-1:0]      column_reg, column_next;
    logic [CW-1:0]      row_reg, row_next;
    logic               run_open_reg, run_open_next;
    logic [CW-1:0]      run_start_reg, run_start_next;
    logic [CW:0]        run_width_reg, run_width_next;
    logic               wrapped_reg, wrapped_next;

    logic [CMP_W-1:0] img_w_x;
    logic [CMP_W-1:0] eff_w;
    logic             accept;
    logic             last_col;
    logic             close;
    logic [CW-1:0]    col_c;
    logic [CW-1:0]    row_c;
    logic             open_c;
    logic [CW-1:0]    start_c;
    logic [CW:0]      width_c;
    logic             wrap_c;

    assign in_ready = init_done && !push_full;
    assign accept   = in_valid && in_ready;

    // image width clamped to 1 .. 2^COORD_BITS
    always_comb
    begin
        img_w_x = CMP_W'(img_w_reg);
        if (img_w_reg == '0)
        begin
            eff_w = CMP_W'(1);
        end
        else if (img_w_x > SPAN_X)
        begin
            eff_w = SPAN_X;
        end
        else
        begin
            eff_w = img_w_x;
        end
    end

    // run tracking for the pixel on the input
    always_comb
    begin
        col_c   = frame_start ? '0 : column_reg;
        row_c   = frame_start ? '0 : row_reg;
        open_c  = frame_start ? 1'b0 : run_open_reg;
        start_c = frame_start ? '0 : run_start_reg;
        width_c = frame_start ? '0 : run_width_reg;
        wrap_c  = frame_start ? 1'b0 : wrapped_reg;

        last_col = (CMP_W'(col_c) >= eff_w - CMP_W'(1));

        run_open_next  = open_c;
        run_start_next = start_c;
        run_width_next = width_c;
        if (pixel_class == PIX_WHITE)
        begin
            if (!open_c)
            begin
                run_open_next  = 1'b1;
                run_start_next = col_c;
                run_width_next = (CW + 1)'(1);
            end
            else if (width_c < SPAN)
            begin
                run_width_next = width_c + (CW + 1)'(1);
            end
        end

        close = run_open_next && ((pixel_class == PIX_BLACK) || last_col);

        push_ctl.clear   = frame_start;
        push_ctl.close   = close;
        push_ctl.wrapped = wrap_c;
        push_start       = run_start_next;
        push_width       = run_width_next;
        push_row         = row_c;
        push_valid       = accept && (frame_start || close);

        if (close)
        begin
            run_open_next  = 1'b0;
            run_width_next = '0;
        end

        // advance coordinates
        wrapped_next = wrap_c;
        if (last_col)
        begin
            column_next = '0;
            row_next    = row_c + CW'(1);
            if (row_c == '1)
            begin
                wrapped_next = 1'b1;
            end
        end
        else
        begin
            column_next = col_c + CW'(1);
            row_next    = row_c;
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg <= IMAGE_WIDTH_RST;
        end
        else if (cfg_wr_en)
        begin
            img_w_reg <= cfg_wr_data;
        end
    end

    // scan state, updated on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= '0;
            row_reg       <= '0;
            run_open_reg  <= 1'b0;
            run_start_reg <= '0;
            run_width_reg <= '0;
            wrapped_reg   <= 1'b0;
        end
        else if (accept)
        begin
            column_reg    <= column_next;
            row_reg       <= row_next;
            run_open_reg  <= run_open_next;
            run_start_reg <= run_start_next;
            run_width_reg <= run_width_next;
            wrapped_reg   <= wrapped_next;
        end
    end

endmodule

FILE: sv/mrbe_back.sv
// box back end: table lookup through a per-column index memory, table scan
// after a row wrap, box table update and result register
// depends on mrbe_pkg, mrbe_ram and assert_macros.svh
`include "assert_macros.svh"

module mrbe_back #(
    parameter int MAX_BOXES  = mrbe_pkg::MAX_BOXES_DEF,
    parameter int COORD_BITS = mrbe_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_empty,
    output logic                          job_pop,
    input  mrbe_pkg::mrbe_job_ctl_t       job_ctl,
    input  logic [COORD_BITS-1:0]         job_start,
    input  logic [COORD_BITS:0]           job_width,
    input  logic [COORD_BITS-1:0]         job_row,
    output logic                          init_done,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mrbe_pkg::KIND_W-1:0]   event_kind,
    output logic [mrbe_pkg::INDEX_W-1:0]  box_index,
    output logic [mrbe_pkg::LEFT_W-1:0]   box_left,
    output logic [mrbe_pkg::TOP_W-1:0]    box_top,
    output logic [mrbe_pkg::BWIDTH_W-1:0] box_width,
    output logic [mrbe_pkg::HEIGHT_W-1:0] box_height
);

    import mrbe_pkg::*;

    localparam int CW        = COORD_BITS;
    localparam int IDX_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W     = $clog2(MAX_BOXES + 1);
    localparam int BOX_W     = 4 * CW + 2;
    localparam int COL_DEPTH = 1 << CW;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BOXES);

    mrbe_state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CW-1:0]    clr_addr_reg, clr_addr_next;
    logic [CW-1:0]    job_start_reg;
    logic [CW:0]      job_width_reg;
    logic [CW-1:0]    job_row_reg;
    logic             job_wrapped_reg;
    logic [IDX_W-1:0] cand_reg, cand_next;
    logic [CNT_W-1:0] scan_reg, scan_next;

    // decision registers
    mrbe_event_t      dec_kind_reg;
    logic [IDX_W-1:0] dec_idx_reg;
    logic [CW-1:0]    dec_left_reg;
    logic [CW-1:0]    dec_top_reg;
    logic [CW:0]      dec_width_reg;
    logic [CW:0]      dec_height_reg;

    // result register
    logic                out_valid_reg;
    mrbe_event_t         out_kind_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic [LEFT_W-1:0]   out_left_reg;
    logic [TOP_W-1:0]    out_top_reg;
    logic [BWIDTH_W-1:0] out_width_reg;
    logic [HEIGHT_W-1:0] out_height_reg;

    // memory ports
    logic             box_we;
    logic [BOX_W-1:0] box_wd;
    logic             box_re;
    logic [IDX_W-1:0] box_ra;
    logic [BOX_W-1:0] box_rd;
    logic             col_we;
    logic [CW-1:0]    col_wa;
    logic [IDX_W-1:0] col_wd;
    logic             col_re;
    logic [IDX_W-1:0] col_rd;

    // fields of the box read from the table
    logic [CW-1:0] rd_left;
    logic [CW-1:0] rd_top;
    logic [CW:0]   rd_width;
    logic [CW:0]   rd_height;
    logic [CW:0]   rd_bottom;
    logic [CW-1:0] row_above;
    logic          pos_match;
    logic          width_eq;

    logic             take_dec;
    logic             grow_sel;
    logic             out_fire;

    assign rd_left   = box_rd[4*CW+1 -: CW];
    assign rd_top    = box_rd[3*CW+1 -: CW];
    assign rd_width  = box_rd[2*CW+1 -: CW+1];
    assign rd_height = box_rd[CW:0];
    assign rd_bottom = {1'b0, rd_top} + rd_height - (CW + 1)'(1);
    assign row_above = job_row_reg - CW'(1);
    assign pos_match = (rd_left == job_start_reg) && (rd_bottom == {1'b0, row_above});
    assign width_eq  = (rd_width == job_width_reg);

    assign init_done = (state_reg != BK_CLEAR);
    assign out_fire  = (state_reg == BK_EMIT) && (!out_valid_reg || out_ready);

    mrbe_ram #(
        .WIDTH (BOX_W),
        .DEPTH (MAX_BOXES)
    ) u_box_ram (
        .clk     (clk),
        .wr_en   (box_we),
        .wr_addr (dec_idx_reg),
        .wr_data (box_wd),
        .rd_en   (box_re),
        .rd_addr (box_ra),
        .rd_data (box_rd)
    );

    mrbe_ram #(
        .WIDTH (IDX_W),
        .DEPTH (COL_DEPTH)
    ) u_col_ram (
        .clk     (clk),
        .wr_en   (col_we),
        .wr_addr (col_wa),
        .wr_data (col_wd),
        .rd_en   (col_re),
        .rd_addr (job_start),
        .rd_data (col_rd)
    );

    // sequencer next state and memory controls
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        clr_addr_next = clr_addr_reg;
        cand_next     = cand_reg;
        scan_next     = scan_reg;
        job_pop       = 1'b0;
        col_re        = 1'b0;
        box_re        = 1'b0;
        box_ra        = cand_reg;
        take_dec      = 1'b0;
        grow_sel      = 1'b0;
        col_we        = 1'b0;
        col_wa        = dec_left_reg;
        col_wd        = dec_idx_reg;
        box_we        = 1'b0;
        box_wd        = {dec_left_reg, dec_top_reg, dec_width_reg, dec_height_reg};

        unique case (state_reg)
            BK_CLEAR:
            begin
                // sweep the column index memory once after reset
                col_we        = 1'b1;
                col_wa        = clr_addr_reg;
                col_wd        = '0;
                clr_addr_next = clr_addr_reg + CW'(1);
                if (clr_addr_reg == '1)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop = 1'b1;
                    if (job_ctl.clear)
                    begin
                        count_next = '0;
                    end
                    if (job_ctl.close)
                    begin
                        col_re     = 1'b1;
                        state_next = BK_COL;
                    end
                end
            end
            BK_COL:
            begin
                if (job_row_reg == '0)
                begin
                    take_dec   = 1'b1;
                    state_next = BK_EMIT;
                end
                else if (job_wrapped_reg)
                begin
                    scan_next  = '0;
                    state_next = BK_SRD;
                end
                else
                begin
                    box_re     = 1'b1;
                    box_ra     = col_rd;
                    cand_next  = col_rd;
                    state_next = BK_CHK;
                end
            end
            BK_CHK:
            begin
                // candidate counts only if it lives in the current table
                take_dec   = 1'b1;
                grow_sel   = (CNT_W'(cand_reg) < count_reg) && pos_match && width_eq;
                state_next = BK_EMIT;
            end
            BK_SRD:
            begin
                if (scan_reg >= count_reg)
                begin
                    take_dec   = 1'b1;
                    state_next = BK_EMIT;
                end
                else
                begin
                    box_re     = 1'b1;
                    box_ra     = scan_reg[IDX_W-1:0];
                    cand_next  = scan_reg[IDX_W-1:0];
                    state_next = BK_SCK;
                end
            end
            BK_SCK:
            begin
                // first box at this position ends the search
                if (pos_match)
                begin
                    take_dec   = 1'b1;
                    grow_sel   = width_eq;
                    state_next = BK_EMIT;
                end
                else
                begin
                    scan_next  = scan_reg + CNT_W'(1);
                    state_next = BK_SRD;
                end
            end
            BK_EMIT:
            begin
                if (out_fire)
                begin
                    if (dec_kind_reg != EV_DROP)
                    begin
                        box_we = 1'b1;
                        col_we = 1'b1;
                    end
                    if (dec_kind_reg == EV_NEW)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_CLEAR;
            count_reg    <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // job and search registers
    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
        scan_reg <= scan_next;
        if (job_pop)
        begin
            job_start_reg   <= job_start;
            job_width_reg   <= job_width;
            job_row_reg     <= job_row;
            job_wrapped_reg <= job_ctl.wrapped;
        end
    end

    // grow, new box or drop
    always_ff @(posedge clk)
    begin
        if (take_dec)
        begin
            if (grow_sel)
            begin
                dec_kind_reg   <= EV_GROW;
                dec_idx_reg    <= cand_reg;
                dec_left_reg   <= rd_left;
                dec_top_reg    <= rd_top;
                dec_width_reg  <= rd_width;
                dec_height_reg <= rd_height + (CW + 1)'(1);
            end
            else
            begin
                dec_kind_reg   <= (count_reg < MAX_CNT) ? EV_NEW : EV_DROP;
                dec_idx_reg    <= count_reg[IDX_W-1:0];
                dec_left_reg   <= job_start_reg;
                dec_top_reg    <= job_row_reg;
                dec_width_reg  <= job_width_reg;
                dec_height_reg <= (CW + 1)'(1);
            end
        end
    end

    // output register, one result per transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_fire)
        begin
            out_kind_reg   <= dec_kind_reg;
            out_index_reg  <= (dec_kind_reg == EV_DROP) ? DROP_INDEX : INDEX_W'(dec_idx_reg);
            out_left_reg   <= LEFT_W'(dec_left_reg);
            out_top_reg    <= TOP_W'(dec_top_reg);
            out_width_reg  <= BWIDTH_W'(dec_width_reg);
            out_height_reg <= HEIGHT_W'(dec_height_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = out_kind_reg;
    assign box_index  = out_index_reg;
    assign box_left   = out_left_reg;
    assign box_top    = out_top_reg;
    assign box_width  = out_width_reg;
    assign box_height = out_height_reg;

    `ASSERT_NEVER(a_count_range, count_reg > MAX_CNT, "box count above table size")
    `ASSERT_CLK(a_grow_in_table, (state_reg == BK_EMIT && dec_kind_reg == EV_GROW) |-> (CNT_W'(dec_idx_reg) < count_reg), "grown box outside the table")
    `ASSERT_CLK(a_drop_only_full, (state_reg == BK_EMIT && dec_kind_reg == EV_DROP) |-> (count_reg == MAX_CNT), "run dropped while the table has room")
    `ASSERT_CLK(a_no_pop_in_clear, (state_reg == BK_CLEAR) |-> !job_pop, "job taken during the clearing sweep")

endmodule

FILE: sv/mask_run_box_extractor.sv
// mask run box extractor top level: front end, job queue, back end; uses mrbe_pkg
// a closed run passes the job queue, column index read, box table read, decision register
// and result register; row 0 skips the table read, after a row wrap the table is scanned
// throughput: 1 pixel per cycle while the queue has room; the back end works on one closed
// run at a time and leaves later jobs in the queue until its result is registered
// reset: a sweep clears the whole column index memory, in_ready stays low until it ends
module mask_run_box_extractor #(
    parameter int MAX_BOXES  = mrbe_pkg::MAX_BOXES_DEF,
    parameter int COORD_BITS = mrbe_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [mrbe_pkg::IMG_W_W-1:0]  cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mrbe_pkg::CLASS_W-1:0]  pixel_class,
    input  logic                          frame_start,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mrbe_pkg::KIND_W-1:0]   event_kind,
    output logic [mrbe_pkg::INDEX_W-1:0]  box_index,
    output logic [mrbe_pkg::LEFT_W-1:0]   box_left,
    output logic [mrbe_pkg::TOP_W-1:0]    box_top,
    output logic [mrbe_pkg::BWIDTH_W-1:0] box_width,
    output logic [mrbe_pkg::HEIGHT_W-1:0] box_height
);

    import mrbe_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int CTL_W = $bits(mrbe_job_ctl_t);
    localparam int JOB_W = CTL_W + CW + (CW + 1) + CW;

    logic          init_done;
    logic          push_valid;
    logic          push_full;
    mrbe_job_ctl_t push_ctl;
    logic [CW-1:0] push_start;
    logic [CW:0]   push_width;
    logic [CW-1:0] push_row;

    logic             pop;
    logic             pop_empty;
    logic [JOB_W-1:0] pop_data;
    mrbe_job_ctl_t    pop_ctl;
    logic [CW-1:0]    pop_start;
    logic [CW:0]      pop_width;
    logic [CW-1:0]    pop_row;

    mrbe_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_class (pixel_class),
        .frame_start (frame_start),
        .init_done   (init_done),
        .push_full   (push_full),
        .push_valid  (push_valid),
        .push_ctl    (push_ctl),
        .push_start  (push_start),
        .push_width  (push_width),
        .push_row    (push_row)
    );

    // job queue
    mrbe_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_data ({push_ctl, push_start, push_width, push_row}),
        .full      (push_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (pop_empty)
    );

    assign pop_ctl   = mrbe_job_ctl_t'(pop_data[JOB_W-1 -: CTL_W]);
    assign pop_start = pop_data[3*CW : 2*CW+1];
    assign pop_width = pop_data[2*CW : CW];
    assign pop_row   = pop_data[CW-1:0];

    mrbe_back #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_empty  (pop_empty),
        .job_pop    (pop),
        .job_ctl    (pop_ctl),
        .job_start  (pop_start),
        .job_width  (pop_width),
        .job_row    (pop_row),
        .init_done  (init_done),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_kind (event_kind),
        .box_index  (box_index),
        .box_left   (box_left),
        .box_top    (box_top),
        .box_width  (box_width),
        .box_height (box_height)
    );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// testbench for mask_run_box_extractor: directed frames and random mask streams
// checked against a built-in box table predictor; needs mrbe_pkg and the rtl top
module tb_top;
    import mrbe_pkg::*;

    localparam int SPAN         = 1 << COORD_BITS_DEF;
    localparam int TABLE_SIZE   = MAX_BOXES_DEF;
    localparam int DRAIN_CYCLES = 800;
    localparam int STALL_LIMIT  = 20000;
    localparam int WIDE_RUN     = 100;

    localparam logic [CLASS_W-1:0] PIX_OTHER   = 2'd2;
    localparam logic [CLASS_W-1:0] PIX_OTHER_B = 2'd3;

    typedef struct {
        mrbe_event_t           kind;
        logic [INDEX_W-1:0]    index;
        logic [LEFT_W-1:0]     left;
        logic [TOP_W-1:0]      top;
        logic [BWIDTH_W-1:0]   width;
        logic [HEIGHT_W-1:0]   height;
    } box_event_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [IMG_W_W-1:0]    cfg_wr_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [CLASS_W-1:0]    pixel_class;
    logic                  frame_start;
    logic                  out_valid;
    logic                  out_ready;
    logic [KIND_W-1:0]     event_kind;
    logic [INDEX_W-1:0]    box_index;
    logic [LEFT_W-1:0]     box_left;
    logic [TOP_W-1:0]      box_top;
    logic [BWIDTH_W-1:0]   box_width;
    logic [HEIGHT_W-1:0]   box_height;

    // predictor state: box table, scan position and open run
    logic [LEFT_W-1:0]     tbl_left   [TABLE_SIZE];
    logic [TOP_W-1:0]      tbl_top    [TABLE_SIZE];
    logic [BWIDTH_W-1:0]   tbl_width  [TABLE_SIZE];
    logic [HEIGHT_W-1:0]   tbl_height [TABLE_SIZE];
    int unsigned           box_total;
    logic [LEFT_W-1:0]     col_pos;
    logic [TOP_W-1:0]      row_pos;
    bit                    run_active;
    logic [LEFT_W-1:0]     run_left;
    logic [BWIDTH_W-1:0]   run_len;
    logic [IMG_W_W-1:0]    cfg_width;

    box_event_t            pending_events [$];
    box_event_t            exp_ev;
    int                    mismatch_count;
    int                    result_count;
    int                    idle_cycles;
    int                    send_idle_pct;
    int                    recv_idle_pct;

    mask_run_box_extractor u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_class (pixel_class),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_kind  (event_kind),
        .box_index   (box_index),
        .box_left    (box_left),
        .box_top     (box_top),
        .box_width   (box_width),
        .box_height  (box_height)
    );

    // clock
    always #2 clk = ~clk;

    // result side back-pressure
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // compare each result transfer with the oldest predicted event
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_events.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result kind %0d index %0d left %0d top %0d",
                                          event_kind, box_index, box_left, box_top));
            end
            else
            begin
                exp_ev = pending_events.pop_front();
                if (event_kind !== exp_ev.kind || box_index !== exp_ev.index ||
                    box_left !== exp_ev.left || box_top !== exp_ev.top ||
                    box_width !== exp_ev.width || box_height !== exp_ev.height)
                begin
                    report_mismatch($sformatf(
                        "result %0d got %0d/%0d/%0d/%0d/%0d/%0d expected %0d/%0d/%0d/%0d/%0d/%0d",
                        result_count, event_kind, box_index, box_left, box_top, box_width,
                        box_height, exp_ev.kind, exp_ev.index, exp_ev.left, exp_ev.top,
                        exp_ev.width, exp_ev.height));
                end
                result_count++;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // zero acts as one, anything past the coordinate span is clamped
    function automatic int unsigned eff_span(input logic [IMG_W_W-1:0] value);
        if (value == 0)
            return 1;
        if (value > SPAN)
            return SPAN;
        return 32'(value);
    endfunction

    // advance the box table by one pixel, queue the event of a closed run
    function automatic void track_box_events(input logic [CLASS_W-1:0] cls, input logic fs);
        int unsigned span;
        int unsigned bottom;
        int          slot;
        bit          at_row_end;
        bit          grown;
        box_event_t  ev;
        if (fs)
        begin
            box_total  = 0;
            col_pos    = '0;
            row_pos    = '0;
            run_active = 1'b0;
            run_left   = '0;
            run_len    = '0;
        end
        span       = eff_span(cfg_width);
        at_row_end = (col_pos >= span - 1);

        // white opens or extends the run
        if (cls == PIX_WHITE)
        begin
            if (!run_active)
            begin
                run_active = 1'b1;
                run_left   = col_pos;
                run_len    = BWIDTH_W'(1);
            end
            else if (run_len < SPAN)
            begin
                run_len = run_len + 1'b1;
            end
        end

        // black or the row end closes the run
        if (run_active && (cls == PIX_BLACK || at_row_end))
        begin
            grown = 1'b0;
            if (row_pos != 0)
            begin
                // first box with same left and bottom on the row above decides
                for (slot = 0; slot < box_total; slot++)
                begin
                    bottom = tbl_top[slot] + tbl_height[slot] - 1;
                    if (tbl_left[slot] == run_left && bottom == row_pos - 1)
                    begin
                        if (tbl_width[slot] == run_len)
                        begin
                            tbl_height[slot] = tbl_height[slot] + 1'b1;
                            ev = '{EV_GROW, slot[INDEX_W-1:0], tbl_left[slot],
                                   tbl_top[slot], tbl_width[slot], tbl_height[slot]};
                            grown = 1'b1;
                        end
                        break;
                    end
                end
            end
            if (!grown)
            begin
                if (box_total < TABLE_SIZE)
                begin
                    tbl_left[box_total]   = run_left;
                    tbl_top[box_total]    = row_pos;
                    tbl_width[box_total]  = run_len;
                    tbl_height[box_total] = HEIGHT_W'(1);
                    ev = '{EV_NEW, box_total[INDEX_W-1:0], run_left, row_pos, run_len, 13'd1};
                    box_total++;
                end
                else
                begin
                    ev = '{EV_DROP, DROP_INDEX, run_left, row_pos, run_len, 13'd1};
                end
            end
            pending_events.push_back(ev);
            run_active = 1'b0;
            run_len    = '0;
        end

        // scan position
        if (at_row_end)
        begin
            col_pos = '0;
            row_pos = row_pos + 1'b1;
        end
        else
        begin
            col_pos = col_pos + 1'b1;
        end
    endfunction

    // one pixel transfer, with an optional gap before it
    task automatic send_pixel(input logic [CLASS_W-1:0] cls, input logic fs);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid    <= 1'b1;
        pixel_class <= cls;
        frame_start <= fs;
        track_box_events(cls, fs);
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // stop sending, wait for every predicted result and let the back end settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_width(input int unsigned value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[IMG_W_W-1:0];
        cfg_width    = value[IMG_W_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // mostly white, some black, a few other colours
    function automatic logic [CLASS_W-1:0] random_class();
        int pick;
        pick = $urandom_range(9);
        if (pick < 5)
            return PIX_WHITE;
        if (pick < 8)
            return PIX_BLACK;
        if (pick == 8)
            return PIX_OTHER;
        return PIX_OTHER_B;
    endfunction

    // reset width, other colours inside and outside a run
    task automatic test_default_width();
        send_pixel(PIX_WHITE, 1'b1);
        send_pixel(PIX_WHITE, 1'b0);
        send_pixel(PIX_OTHER, 1'b0);
        send_pixel(PIX_WHITE, 1'b0);
        send_pixel(PIX_BLACK, 1'b0);
        send_pixel(PIX_OTHER_B, 1'b0);
        send_pixel(PIX_BLACK, 1'b0);
        send_pixel(PIX_WHITE, 1'b0);
        send_pixel(PIX_BLACK, 1'b0);
    endtask

    // zero width acting as one, then growth and width mismatch on short rows
    task automatic test_narrow_rows();
        wait_idle();
        write_width(0);
        send_pixel(PIX_WHITE, 1'b1);
        send_pixel(PIX_WHITE, 1'b0);
        send_pixel(PIX_OTHER, 1'b0);
        send_pixel(PIX_WHITE, 1'b0);

        wait_idle();
        write_width(3);
        for (int r = 0; r < 4; r++)
        begin
            send_pixel(PIX_WHITE, r == 0);
            send_pixel(PIX_WHITE, 1'b0);
            send_pixel((r < 2) ? PIX_BLACK : PIX_WHITE, 1'b0);
        end
        send_pixel(PIX_BLACK, 1'b0);
        send_pixel(PIX_WHITE, 1'b0);
        send_pixel(PIX_OTHER, 1'b0);
    endtask

    // width lowered mid-row: the next pixel counts as the row end
    task automatic test_past_row_end();
        wait_idle();
        write_width(100);
        send_pixel(PIX_BLACK, 1'b1);
        repeat (49) send_pixel(PIX_BLACK, 1'b0);
        wait_idle();
        write_width(10);
        send_pixel(PIX_WHITE, 1'b0);
        send_pixel(PIX_WHITE, 1'b0);
        send_pixel(PIX_BLACK, 1'b0);
    endtask

    // oversized width clamped to the span, long run closed by a black pixel
    task automatic test_wide_row();
        wait_idle();
        write_width((1 << IMG_W_W) - 1);
        send_pixel(PIX_WHITE, 1'b1);
        repeat (WIDE_RUN - 2) send_pixel(PIX_WHITE, 1'b0);
        send_pixel(PIX_BLACK, 1'b0);
    endtask

    // overflow of the box table, drop at the last column, then frame restart
    task automatic test_table_full();
        int unsigned row_len;
        row_len = 2 * (TABLE_SIZE + 4) + 2;
        wait_idle();
        write_width(row_len);
        for (int k = 0; k < TABLE_SIZE + 4; k++)
        begin
            send_pixel(PIX_WHITE, k == 0);
            send_pixel(PIX_BLACK, 1'b0);
        end
        send_pixel(PIX_WHITE, 1'b0);
        send_pixel(PIX_WHITE, 1'b0);
        send_pixel(PIX_WHITE, 1'b1);
        send_pixel(PIX_BLACK, 1'b0);
    endtask

    // random frames: repeated row patterns with noise, width changed between groups
    task automatic test_random_frames(input int n_items);
        int          sent;
        int          sel;
        int unsigned new_width;
        int unsigned span;
        int          n_rows;
        bit          fs_first;
        logic [CLASS_W-1:0] row_pattern [64];
        logic [CLASS_W-1:0] cls;
        sent = 0;
        while (sent < n_items)
        begin
            wait_idle();
            sel = $urandom_range(99);
            if (sel < 80)
                new_width = $urandom_range(1, 12);
            else if (sel < 92)
                new_width = $urandom_range(13, 64);
            else if (sel < 94)
                new_width = 0;
            else if (sel < 96)
                new_width = (1 << IMG_W_W) - 1;
            else
                new_width = $urandom_range(65, (1 << IMG_W_W) - 1);
            write_width(new_width);
            span = eff_span(IMG_W_W'(new_width));

            repeat ($urandom_range(1, 3))
            begin
                if (sent >= n_items)
                    break;
                fs_first = ($urandom_range(99) < 90);
                if (span > 64)
                begin
                    // wide image: a stretch of random pixels that may cross a row end
                    repeat ($urandom_range(20, 120))
                    begin
                        send_pixel(random_class(), fs_first);
                        fs_first = 1'b0;
                        sent++;
                    end
                end
                else
                begin
                    n_rows = $urandom_range(1, 10);
                    for (int c = 0; c < span; c++)
                        row_pattern[c] = random_class();
                    for (int r = 0; r < n_rows && sent < n_items; r++)
                    begin
                        if (r > 0 && $urandom_range(99) < 30)
                        begin
                            for (int c = 0; c < span; c++)
                                row_pattern[c] = random_class();
                        end
                        for (int c = 0; c < span; c++)
                        begin
                            cls = row_pattern[c];
                            if ($urandom_range(99) < 8)
                                cls = CLASS_W'($urandom_range(0, 3));
                            send_pixel(cls, fs_first || ($urandom_range(999) < 3));
                            fs_first = 1'b0;
                            sent++;
                        end
                    end
                end
            end
        end
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        in_valid       = 1'b0;
        pixel_class    = PIX_BLACK;
        frame_start    = 1'b0;
        out_ready      = 1'b0;
        mismatch_count = 0;
        result_count   = 0;
        idle_cycles    = 0;
        send_idle_pct  = 11;
        recv_idle_pct  = 75;
        box_total      = 0;
        col_pos        = '0;
        row_pos        = '0;
        run_active     = 1'b0;
        run_left       = '0;
        run_len        = '0;
        cfg_width      = IMAGE_WIDTH_RST;

        // reset, then wait out the index memory sweep
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);

        test_default_width();
        test_narrow_rows();
        test_past_row_end();
        test_wide_row();
        test_table_full();
        test_random_frames(300);

        send_idle_pct = 75;
        recv_idle_pct = 11;
        test_random_frames(300);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_frames(300);

        wait_idle();
        if (pending_events.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_events.size()));
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/mrbe_pkg.sv
sv/mrbe_ram.sv
sv/mrbe_fifo.sv
sv/mrbe_front.sv
sv/mrbe_back.sv
sv/mask_run_box_extractor.sv
bench/tb_top.sv
